@@ hdl/lftl_pkg.sv @@
// ----------------------------------------------------------------------------
// lftl_pkg: shared types for the line frame table lookup
// item and result structs, search token and cell command
// ----------------------------------------------------------------------------
package lftl_pkg;

  // frame index fields are sized for the largest supported table
  localparam int IDX_W = 12;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DIV
  } state_e;

  typedef enum logic [1:0] {
    CFG_TRANSLATE = 2'd0,
    CFG_SWEEP     = 2'd1,
    CFG_WINDOW    = 2'd2,
    CFG_BASE      = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic        action;
    logic [47:0] address;
    logic        read_only;
    logic        is_write;
  } in_t;

  typedef struct packed {
    logic        hit;
    logic        fault;
    logic [7:0]  frame_index;
    logic [47:0] local_address;
    logic        writeback_needed;
    logic [47:0] evicted_tag;
  } out_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic             vld;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             free;
    logic [IDX_W-1:0] free_idx;
    logic [63:0]      oldest;
    logic [IDX_W-1:0] old_idx;
    logic             old_ro;
    logic [47:0]      old_tag;
  } tok_t;

  // update broadcast to every cell
  typedef struct packed {
    logic             wr_en;
    logic             install;
    logic             wr_ro;
    logic [IDX_W-1:0] wr_idx;
    logic             sw_en;
    logic [63:0]      cutoff;
  } cmd_t;

endpackage

@@ hdl/lftl_cell.sv @@
// ----------------------------------------------------------------------------
// lftl_cell: one frame of the table
// holds the frame state and folds it into the passing search token
// ----------------------------------------------------------------------------
module lftl_cell #(
  parameter int IDX  = 0,
  parameter int SCAN = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [47:0]         key_i,
  input  logic [63:0]         tick_i,
  input  lftl_pkg::cmd_t      cmd_i,
  input  lftl_pkg::tok_t      tok_i,
  output lftl_pkg::tok_t      tok_o
);

  localparam logic [lftl_pkg::IDX_W-1:0] MY = lftl_pkg::IDX_W'(IDX);

  logic        valid_q, ref_q, ro_q;
  logic [47:0] tag_q;
  logic [63:0] stamp_q;
  lftl_pkg::tok_t tok_d, tok_q;

  always_comb begin
    tok_d = tok_i;
    if (valid_q && !tok_i.hit && tag_q == key_i) begin
      tok_d.hit     = 1'b1;
      tok_d.hit_idx = MY;
    end
    if (!valid_q) begin
      tok_d.free     = 1'b1;
      tok_d.free_idx = MY;
    end
    // frame 0 is the fallback victim
    if (IDX == 0) begin
      tok_d.old_ro  = ro_q;
      tok_d.old_tag = tag_q;
    end
    if (IDX < SCAN && stamp_q < tok_i.oldest) begin
      tok_d.oldest  = stamp_q;
      tok_d.old_idx = MY;
      tok_d.old_ro  = ro_q;
      tok_d.old_tag = tag_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ref_q   <= 1'b0;
      ro_q    <= 1'b0;
      stamp_q <= '0;
    end else begin
      if (cmd_i.wr_en && cmd_i.wr_idx == MY) begin
        ref_q   <= 1'b1;
        stamp_q <= tick_i;
        if (cmd_i.install) begin
          valid_q <= 1'b1;
          ro_q    <= cmd_i.wr_ro;
        end
      end else if (cmd_i.sw_en && valid_q && ref_q && stamp_q < cmd_i.cutoff) begin
        ref_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && cmd_i.install && cmd_i.wr_idx == MY) begin
      tag_q <= key_i;
    end
  end

endmodule

@@ hdl/line_frame_table_lookup.sv @@
// ----------------------------------------------------------------------------
// line_frame_table_lookup: fully associative table of local line frames
// lookup, allocation and reference aging over a chain of frame cells
// ----------------------------------------------------------------------------
// A lookup in virtual mode sends a search token down a chain of FRAMES cells,
// one cell per cycle; between the accepted start and the result strobe lie the
// launch register, the FRAMES cell registers and the result register. A real-
// mode lookup gives its result in the cycle after start. A tick runs a bit-
// serial remainder over the 64-bit time when the sweep interval is nonzero,
// one bit per cycle, and gives its result in the cycle after start otherwise.
// Results appear on result_o for exactly one cycle with done_o high; the
// receiver cannot stall, so every transfer is taken when it is shown. Start is
// taken only while busy_o is low. LINE_BYTES is expected to be a power of two.
// ----------------------------------------------------------------------------
module line_frame_table_lookup #(
  parameter int FRAMES      = 256,
  parameter int LINE_BYTES  = 16,
  parameter int VICTIM_SCAN = 25
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  lftl_pkg::in_t    data_i,
  output logic             done_o,
  output lftl_pkg::out_t   result_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [15:0]      cfg_data_i
);

  localparam int SCAN  = (VICTIM_SCAN < FRAMES) ? VICTIM_SCAN : FRAMES;
  localparam int OFS_W = $clog2(LINE_BYTES);

  // configuration registers
  logic        te_q;
  logic [15:0] si_q;
  logic [7:0]  wf_q;
  logic [15:0] lb_q;

  // control and datapath state
  lftl_pkg::state_e state_q, state_d;
  logic [63:0]      tick_q;
  logic [47:0]      key_q;
  logic [OFS_W-1:0] ofs_q;
  logic             ro_q;
  logic [63:0]      dvd_q;
  logic [15:0]      rem_q, rem_d;
  logic [5:0]       cnt_q;
  logic             done_q, done_d;
  lftl_pkg::out_t   res_q, res_d;
  lftl_pkg::tok_t   tok0_q, tok0_d;
  lftl_pkg::cmd_t   cmd;

  lftl_pkg::tok_t   chain [0:FRAMES];

  logic accept;
  logic last_step;
  logic [16:0] rstep;
  logic [23:0] span;
  logic [63:0] cutoff;
  logic [lftl_pkg::IDX_W-1:0] sel_idx;
  logic [47:0] local_addr;

  assign accept    = start_i && (state_q == lftl_pkg::ST_IDLE);
  assign busy_o    = (state_q != lftl_pkg::ST_IDLE);
  assign last_step = (cnt_q == 6'd63);

  // bit-serial remainder of the new time by the sweep interval
  assign rstep = {rem_q, dvd_q[63]};
  always_comb begin
    if (rstep >= {1'b0, si_q}) begin
      rem_d = 16'(rstep - {1'b0, si_q});
    end else begin
      rem_d = rstep[15:0];
    end
  end

  // aging cutoff, clamped at zero
  assign span   = 24'(si_q) * 24'(wf_q);
  assign cutoff = (tick_q > 64'(span)) ? tick_q - 64'(span) : 64'd0;

  // frame chosen when the token leaves the chain
  always_comb begin
    if (chain[FRAMES].hit) begin
      sel_idx = chain[FRAMES].hit_idx;
    end else if (chain[FRAMES].free) begin
      sel_idx = chain[FRAMES].free_idx;
    end else begin
      sel_idx = chain[FRAMES].old_idx;
    end
  end

  assign local_addr = 48'({32'd0, lb_q} + 48'(sel_idx) * 48'(LINE_BYTES) + 48'(ofs_q));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lftl_pkg::ST_IDLE: begin
        if (accept && data_i.action) begin
          if (si_q != 16'd0) state_d = lftl_pkg::ST_DIV;
        end else if (accept && te_q) begin
          state_d = lftl_pkg::ST_SEARCH;
        end
      end
      lftl_pkg::ST_SEARCH: begin
        if (chain[FRAMES].vld) state_d = lftl_pkg::ST_IDLE;
      end
      lftl_pkg::ST_DIV: begin
        if (last_step) state_d = lftl_pkg::ST_IDLE;
      end
      default: state_d = lftl_pkg::ST_IDLE;
    endcase
  end

  // outputs, token launch and cell commands
  always_comb begin
    done_d = 1'b0;
    res_d  = '0;
    tok0_d = '0;
    cmd    = '0;
    case (state_q)
      lftl_pkg::ST_IDLE: begin
        if (accept) begin
          if (data_i.action) begin
            done_d = (si_q == 16'd0);
          end else if (!te_q) begin
            done_d              = 1'b1;
            res_d.local_address = data_i.address;
          end else begin
            tok0_d.vld    = 1'b1;
            tok0_d.oldest = tick_q;
          end
        end
      end
      lftl_pkg::ST_SEARCH: begin
        if (chain[FRAMES].vld) begin
          done_d              = 1'b1;
          res_d.hit           = chain[FRAMES].hit;
          res_d.fault         = !chain[FRAMES].hit;
          res_d.frame_index   = 8'(sel_idx);
          res_d.local_address = local_addr;
          if (!chain[FRAMES].hit && !chain[FRAMES].free) begin
            res_d.writeback_needed = !chain[FRAMES].old_ro;
            res_d.evicted_tag      = chain[FRAMES].old_tag;
          end
          cmd.wr_en   = 1'b1;
          cmd.install = !chain[FRAMES].hit;
          cmd.wr_ro   = ro_q;
          cmd.wr_idx  = sel_idx;
        end
      end
      lftl_pkg::ST_DIV: begin
        if (last_step) begin
          done_d     = 1'b1;
          cmd.sw_en  = (rem_d == 16'd0);
          cmd.cutoff = cutoff;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lftl_pkg::ST_IDLE;
      tick_q  <= 64'd1;
      done_q  <= 1'b0;
      tok0_q  <= '0;
      cnt_q   <= '0;
      te_q    <= 1'b0;
      si_q    <= 16'd100;
      wf_q    <= 8'd10;
      lb_q    <= 16'd0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      tok0_q  <= tok0_d;
      if (accept && data_i.action) tick_q <= tick_q + 64'd1;
      if (state_q == lftl_pkg::ST_DIV) cnt_q <= cnt_q + 6'd1;
      else                             cnt_q <= '0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          lftl_pkg::CFG_TRANSLATE: te_q <= cfg_data_i[0];
          lftl_pkg::CFG_SWEEP:     si_q <= cfg_data_i;
          lftl_pkg::CFG_WINDOW:    wf_q <= cfg_data_i[7:0];
          lftl_pkg::CFG_BASE:      lb_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept) begin
      key_q <= data_i.address - 48'(data_i.address % 48'(LINE_BYTES));
      ofs_q <= OFS_W'(data_i.address % 48'(LINE_BYTES));
      ro_q  <= data_i.read_only && !data_i.is_write;
      dvd_q <= tick_q + 64'd1;
      rem_q <= '0;
    end else if (state_q == lftl_pkg::ST_DIV) begin
      dvd_q <= {dvd_q[62:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // chain of frame cells
  assign chain[0] = tok0_q;

  for (genvar k = 0; k < FRAMES; k++) begin : g_cell
    lftl_cell #(
      .IDX  (k),
      .SCAN (SCAN)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .key_i  (key_q),
      .tick_i (tick_q),
      .cmd_i  (cmd),
      .tok_i  (chain[k]),
      .tok_o  (chain[k+1])
    );
  end

endmodule

@@ tb/lftl_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lftl_checker: result predictor and scoreboard for the line frame table
// keeps its own copy of the frame table, time and registers, predicts each
// accepted transfer and compares every strobed result field by field
// ----------------------------------------------------------------------------
module lftl_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           busy_i,
  input  lftl_pkg::in_t  data_i,
  input  logic           done_i,
  input  lftl_pkg::out_t result_i,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [15:0]    cfg_data_i,
  output int             fail_count_o,
  output int             pending_o
);

  localparam int NFRAMES = 256;
  localparam int SCAN    = 25;

  // shadow registers
  logic        xlate_on;
  logic [15:0] sweep_ticks;
  logic [7:0]  window_mult;
  logic [15:0] frame_base;

  // shadow frame table
  logic        fr_valid [NFRAMES];
  logic        fr_refd  [NFRAMES];
  logic        fr_ro    [NFRAMES];
  logic [47:0] fr_tag   [NFRAMES];
  logic [63:0] fr_stamp [NFRAMES];
  logic [63:0] now_ticks;

  lftl_pkg::out_t expected_results[$];

  assign pending_o = expected_results.size();

  function automatic lftl_pkg::out_t lookup_or_tick(lftl_pkg::in_t it);
    lftl_pkg::out_t r;
    logic [47:0] ltag;
    logic [3:0]  off;
    logic [63:0] span, cutoff, oldest;
    int          victim;
    bit          free_found;
    r = '0;
    if (it.action) begin
      now_ticks = now_ticks + 64'd1;
      if (sweep_ticks != 0 && (now_ticks % 64'(sweep_ticks)) == 0) begin
        span   = 64'(sweep_ticks) * 64'(window_mult);
        cutoff = (now_ticks > span) ? now_ticks - span : 64'd0;
        for (int i = 0; i < NFRAMES; i++)
          if (fr_valid[i] && fr_refd[i] && fr_stamp[i] < cutoff) fr_refd[i] = 1'b0;
      end
      return r;
    end
    if (!xlate_on) begin
      r.local_address = it.address;
      return r;
    end
    off  = it.address[3:0];
    ltag = {it.address[47:4], 4'h0};
    for (int i = 0; i < NFRAMES; i++) begin
      if (fr_valid[i] && fr_tag[i] == ltag) begin
        fr_refd[i]      = 1'b1;
        fr_stamp[i]     = now_ticks;
        r.hit           = 1'b1;
        r.frame_index   = 8'(i);
        r.local_address = 48'(frame_base) + 48'(i) * 48'd16 + 48'(off);
        return r;
      end
    end
    // highest free frame wins, else oldest stamp in the scan window
    victim     = 0;
    free_found = 0;
    for (int i = 0; i < NFRAMES; i++)
      if (!fr_valid[i]) begin
        victim     = i;
        free_found = 1;
      end
    if (!free_found) begin
      oldest = now_ticks;
      for (int i = 0; i < SCAN; i++)
        if (fr_stamp[i] < oldest) begin
          oldest = fr_stamp[i];
          victim = i;
        end
      r.writeback_needed = !fr_ro[victim];
      r.evicted_tag      = fr_tag[victim];
    end
    fr_valid[victim] = 1'b1;
    fr_refd[victim]  = 1'b1;
    fr_ro[victim]    = it.read_only && !it.is_write;
    fr_tag[victim]   = ltag;
    fr_stamp[victim] = now_ticks;
    r.fault          = 1'b1;
    r.frame_index    = 8'(victim);
    r.local_address  = 48'(frame_base) + 48'(victim) * 48'd16 + 48'(off);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lftl_pkg::out_t want;
    if (!rst_ni) begin
      xlate_on    = 1'b0;
      sweep_ticks = 16'd100;
      window_mult = 8'd10;
      frame_base  = 16'd0;
      now_ticks   = 64'd1;
      for (int i = 0; i < NFRAMES; i++) begin
        fr_valid[i] = 1'b0;
        fr_refd[i]  = 1'b0;
        fr_ro[i]    = 1'b0;
        fr_tag[i]   = '0;
        fr_stamp[i] = '0;
      end
      expected_results.delete();
      fail_count_o <= 0;
    end else begin
      if (done_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, result_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_results.pop_front();
          if (want.hit !== result_i.hit || want.fault !== result_i.fault ||
              want.frame_index !== result_i.frame_index ||
              want.local_address !== result_i.local_address ||
              want.writeback_needed !== result_i.writeback_needed ||
              want.evicted_tag !== result_i.evicted_tag) begin
            $display("%0t: result mismatch", $time);
            $display("  expected hit=%b fault=%b idx=%0d laddr=%h wb=%b evtag=%h",
                     want.hit, want.fault, want.frame_index, want.local_address,
                     want.writeback_needed, want.evicted_tag);
            $display("  actual   hit=%b fault=%b idx=%0d laddr=%h wb=%b evtag=%h",
                     result_i.hit, result_i.fault, result_i.frame_index,
                     result_i.local_address, result_i.writeback_needed,
                     result_i.evicted_tag);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      // register writes only come while idle, so order against items is moot
      if (cfg_we_i) begin
        case (lftl_pkg::cfg_idx_e'(cfg_idx_i))
          lftl_pkg::CFG_TRANSLATE: xlate_on    = cfg_data_i[0];
          lftl_pkg::CFG_SWEEP:     sweep_ticks = cfg_data_i;
          lftl_pkg::CFG_WINDOW:    window_mult = cfg_data_i[7:0];
          lftl_pkg::CFG_BASE:      frame_base  = cfg_data_i;
          default: ;
        endcase
      end
      if (start_i && !busy_i) expected_results.push_back(lookup_or_tick(data_i));
    end
  end

endmodule

@@ tb/line_frame_table_lookup_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_frame_table_lookup_test: stimulus and verdict for the frame table
// directed corners, then register phases of mixed lookups and ticks drawn
// from a hot line set so the table fills, hits and evicts
// ----------------------------------------------------------------------------
module line_frame_table_lookup_test;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOT_LINES   = 300;   // more than the table, forces eviction
  localparam int PHASE_ITEMS = 180;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start_i = 1'b0;
  logic           busy_o;
  lftl_pkg::in_t  data_i = '0;
  logic           done_o;
  lftl_pkg::out_t result_o;
  logic           cfg_we_i = 1'b0;
  logic [1:0]     cfg_idx_i = '0;
  logic [15:0]    cfg_data_i = '0;

  int fail_count, pending;
  int cycles = 0;
  int lookups_sent = 0, ticks_sent = 0;

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  line_frame_table_lookup u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .data_i, .done_o, .result_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  lftl_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .data_i, .done_i(done_o),
    .result_i(result_o), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // one transfer: hold start until the block takes it, leave at a falling edge
  task automatic send(lftl_pkg::in_t it);
    start_i <= 1'b1;
    data_i  <= it;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
    if (it.action) ticks_sent++;
    else lookups_sent++;
  endtask

  // mostly back to back or short gaps, now and then a long one
  task automatic idle_gap();
    int pick, len;
    pick = $urandom_range(0, 99);
    len  = (pick < 45) ? 0 : (pick < 90) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    if (len > 0) begin
      start_i <= 1'b0;
      repeat (len) @(negedge clk_i);
    end
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(lftl_pkg::cfg_idx_e idx, logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic set_mode(logic xl, logic [15:0] sweep, logic [7:0] win, logic [15:0] base);
    write_reg(lftl_pkg::CFG_TRANSLATE, {15'd0, xl});
    write_reg(lftl_pkg::CFG_SWEEP, sweep);
    write_reg(lftl_pkg::CFG_WINDOW, {8'd0, win});
    write_reg(lftl_pkg::CFG_BASE, base);
    @(negedge clk_i);
  endtask

  function automatic lftl_pkg::in_t make_lookup(logic [47:0] addr, logic ro, logic wr);
    lftl_pkg::in_t it;
    it           = '0;
    it.address   = addr;
    it.read_only = ro;
    it.is_write  = wr;
    return it;
  endfunction

  // random item: ticks, hot-set lookups, and fully random addresses
  function automatic lftl_pkg::in_t random_item();
    lftl_pkg::in_t it;
    int            pick;
    logic [43:0]   line;
    pick = $urandom_range(0, 99);
    line = 44'($urandom_range(0, HOT_LINES - 1)) * 44'h1_0000_0001;
    it = make_lookup({line, 4'($urandom)}, 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
    if (pick < 25) begin
      it.action = 1'b1;
    end else if (pick < 40) begin
      it.address = {16'($urandom), 32'($urandom)};
    end
    // a tick ignores the other fields, fill them anyway so every bit toggles
    if (it.action) it.address = {16'($urandom), 32'($urandom)};
    return it;
  endfunction

  initial begin
    lftl_pkg::in_t tick_item;
    tick_item        = '0;
    tick_item.action = 1'b1;

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // real mode straight out of reset: address passes through
    send(make_lookup('0, 1'b0, 1'b0));
    send(make_lookup('1, 1'b1, 1'b1));
    send(tick_item);
    drain();

    // virtual mode at the top local base
    set_mode(1'b1, 16'd1, 8'd1, 16'hFFFF);
    send(make_lookup('0, 1'b0, 1'b0));                 // miss into the last frame
    send(make_lookup(48'h0000_0000_000F, 1'b0, 1'b0)); // hit, top offset
    send(make_lookup('1, 1'b1, 1'b0));                 // read-only install
    send(make_lookup(48'hFFFF_FFFF_FFF0, 1'b1, 1'b1)); // hit, write leaves ro alone
    send(make_lookup(48'hAAAA_AAAA_AAA5, 1'b1, 1'b1)); // write forces writable
    send(tick_item);                                   // sweep every tick
    send(tick_item);
    send(make_lookup(48'h5555_5555_555A, 1'b0, 1'b1));
    send(make_lookup('0, 1'b0, 1'b1));
    drain();

    // register phases, extremes first; the table carries over between them
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_mode(1'b1, 16'd1,     8'd1,   16'hFFFF);
        1: set_mode(1'b1, 16'hFFFF,  8'd255, 16'h0000);
        2: set_mode(1'b0, 16'd7,     8'd3,   16'h00FF);  // real mode
        3: set_mode(1'b1, 16'd0,     8'd10,  16'h1234);  // sweep never fires
        4: set_mode(1'b1, 16'd3,     8'd2,   16'h8000);
        default: set_mode(1'b1, 16'd100, 8'd10, 16'h0000);
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send(random_item());
        idle_gap();
      end
      drain();
    end

    // give any straggling result time to come back before the verdict
    repeat (1000) @(negedge clk_i);

    $display("covered %0d lookups and %0d ticks over six register settings,",
             lookups_sent, ticks_sent);
    $display("real and virtual mode, hot-line hits, fills and evictions");
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
